FILE: src/slcfp_pkg.sv
// Shared types, codes and the CRC16-CCITT byte update for the frame parser.
// Used by the controller, the datapath, the top level and the checker.
package slcfp_pkg;

  // Default depth of the payload buffer.
  localparam int MaxPayloadDefault = 64;

  // Result status codes.
  localparam logic [1:0] StatusGood   = 2'd0;
  localparam logic [1:0] StatusLenErr = 2'd1;
  localparam logic [1:0] StatusCrcErr = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CfgSyncFirst  = 2'd0;
  localparam logic [1:0] CfgSyncSecond = 2'd1;
  localparam logic [1:0] CfgMaxLength  = 2'd2;
  localparam logic [1:0] CfgCrcSeed    = 2'd3;

  // Register reset values.
  localparam logic [7:0]  SyncFirstReset  = 8'hAA;
  localparam logic [7:0]  SyncSecondReset = 8'h55;
  localparam logic [6:0]  MaxLengthReset  = 7'd64;
  localparam logic [15:0] CrcSeedReset    = 16'hFFFF;

  localparam logic [15:0] CrcPoly = 16'h1021;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       start_frame;
    logic       load_len;
    logic       load_cmd;
    logic       store_payload;
    logic       load_crc_lo;
    logic       emit_err;
    logic [1:0] err_status;
    logic       emit_empty;
    logic       start_drain;
    logic       drain_step;
  } slcfp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sync1_hit;
    logic sync2_hit;
    logic len_bad;
    logic len_zero;
    logic payload_done;
    logic crc_ok;
    logic drain_last;
    logic out_free;
  } slcfp_stat_t;

  // One byte of CRC16-CCITT, MSB first, not reflected.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int          i;
    c = crc ^ {b, 8'h00};
    for (i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: src/slcfp_ctrl.sv
// Frame parser controller: the phase state machine and the input handshake.
// Depends on slcfp_pkg for the command and status structs and status codes.
module slcfp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  slcfp_pkg::slcfp_stat_t stat_i,
  output slcfp_pkg::slcfp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    StHunt,
    StSync2,
    StLength,
    StCommand,
    StPayload,
    StCrcLo,
    StCrcHi,
    StDrain
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  always_comb begin
    in_stall_o = 1'b0;
    unique case (state_q)
      StDrain:           in_stall_o = 1'b1;
      StLength, StCrcHi: in_stall_o = !stat_i.out_free;
      default:           in_stall_o = 1'b0;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StHunt: begin
        if (accept && stat_i.sync1_hit) begin
          cmd_o.start_frame = 1'b1;
          state_d           = StSync2;
        end
      end
      StSync2: begin
        if (accept) begin
          if (stat_i.sync2_hit) begin
            state_d = StLength;
          end else if (stat_i.sync1_hit) begin
            cmd_o.start_frame = 1'b1;
            state_d           = StSync2;
          end else begin
            state_d = StHunt;
          end
        end
      end
      StLength: begin
        if (accept) begin
          if (stat_i.len_bad) begin
            cmd_o.emit_err   = 1'b1;
            cmd_o.err_status = slcfp_pkg::StatusLenErr;
            state_d          = StHunt;
          end else begin
            cmd_o.load_len = 1'b1;
            state_d        = StCommand;
          end
        end
      end
      StCommand: begin
        if (accept) begin
          cmd_o.load_cmd = 1'b1;
          state_d        = stat_i.len_zero ? StCrcLo : StPayload;
        end
      end
      StPayload: begin
        if (accept) begin
          cmd_o.store_payload = 1'b1;
          if (stat_i.payload_done) begin
            state_d = StCrcLo;
          end
        end
      end
      StCrcLo: begin
        if (accept) begin
          cmd_o.load_crc_lo = 1'b1;
          state_d           = StCrcHi;
        end
      end
      StCrcHi: begin
        if (accept) begin
          if (!stat_i.crc_ok) begin
            cmd_o.emit_err   = 1'b1;
            cmd_o.err_status = slcfp_pkg::StatusCrcErr;
            state_d          = StHunt;
          end else if (stat_i.len_zero) begin
            cmd_o.emit_empty = 1'b1;
            state_d          = StHunt;
          end else begin
            cmd_o.start_drain = 1'b1;
            state_d           = StDrain;
          end
        end
      end
      StDrain: begin
        if (stat_i.out_free) begin
          cmd_o.drain_step = 1'b1;
          if (stat_i.drain_last) begin
            state_d = StHunt;
          end
        end
      end
      default: state_d = StHunt;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StHunt;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/slcfp_dp.sv
// Frame parser datapath: configuration registers, running CRC, frame fields,
// payload buffer and the output register. Depends on slcfp_pkg.
module slcfp_dp #(
  parameter int MaxPayload = slcfp_pkg::MaxPayloadDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [15:0]            cfg_data_i,
  input  logic [7:0]             rx_byte_i,
  input  slcfp_pkg::slcfp_cmd_t  cmd_i,
  output slcfp_pkg::slcfp_stat_t stat_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic [7:0]             command_o,
  output logic [6:0]             length_o,
  output logic [7:0]             payload_byte_o,
  output logic [5:0]             byte_index_o,
  output logic                   last_o
);

  // Lengths never exceed 127, so the buffer never needs more entries than that.
  localparam int Depth = (MaxPayload < 128) ? MaxPayload : 128;
  localparam int Aw    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [7:0] LimitCap = 8'(MaxPayload);

  logic [7:0]  sync_first_q, sync_second_q;
  logic [6:0]  max_length_q;
  logic [15:0] crc_seed_q;

  logic [15:0] crc_q;
  logic [6:0]  len_q;
  logic [7:0]  cmd_q;
  logic [6:0]  count_q;
  logic [7:0]  crc_lo_q;

  logic [7:0]  mem_q [Depth];
  logic [7:0]  rd_data_q;
  logic [6:0]  rd_idx_q;
  logic [6:0]  rd_next;

  logic        out_valid_q;
  logic [1:0]  status_q;
  logic [7:0]  command_q;
  logic [6:0]  length_q;
  logic [7:0]  payload_q;
  logic [5:0]  index_q;
  logic        last_q;

  logic [7:0]  limit;
  logic [7:0]  count_inc;
  logic        out_free;
  logic        out_load;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= slcfp_pkg::SyncFirstReset;
      sync_second_q <= slcfp_pkg::SyncSecondReset;
      max_length_q  <= slcfp_pkg::MaxLengthReset;
      crc_seed_q    <= slcfp_pkg::CrcSeedReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        slcfp_pkg::CfgSyncFirst:  sync_first_q  <= cfg_data_i[7:0];
        slcfp_pkg::CfgSyncSecond: sync_second_q <= cfg_data_i[7:0];
        slcfp_pkg::CfgMaxLength:  max_length_q  <= cfg_data_i[6:0];
        slcfp_pkg::CfgCrcSeed:    crc_seed_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign limit     = ({1'b0, max_length_q} < LimitCap) ? {1'b0, max_length_q} : LimitCap;
  assign count_inc = {1'b0, count_q} + 8'd1;
  assign rd_next   = rd_idx_q + 7'd1;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign out_load  = cmd_i.emit_err || cmd_i.emit_empty || cmd_i.drain_step;

  always_comb begin
    stat_o              = '0;
    stat_o.sync1_hit    = (rx_byte_i == sync_first_q);
    stat_o.sync2_hit    = (rx_byte_i == sync_second_q);
    stat_o.len_bad      = (rx_byte_i > limit);
    stat_o.len_zero     = (len_q == 7'd0);
    stat_o.payload_done = (count_inc >= {1'b0, len_q});
    stat_o.crc_ok       = ({rx_byte_i, crc_lo_q} == crc_q);
    stat_o.drain_last   = (rd_next == len_q);
    stat_o.out_free     = out_free;
  end

  // Frame registers; their reset values are never observed before a load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= slcfp_pkg::CrcSeedReset;
      len_q    <= '0;
      cmd_q    <= '0;
      count_q  <= '0;
      crc_lo_q <= '0;
      rd_idx_q <= '0;
    end else begin
      if (cmd_i.start_frame) begin
        crc_q   <= crc_seed_q;
        count_q <= '0;
      end
      if (cmd_i.load_len) begin
        len_q <= rx_byte_i[6:0];
        crc_q <= slcfp_pkg::crc16_byte(crc_seed_q, rx_byte_i);
      end
      if (cmd_i.load_cmd) begin
        cmd_q   <= rx_byte_i;
        crc_q   <= slcfp_pkg::crc16_byte(crc_q, rx_byte_i);
        count_q <= '0;
      end
      if (cmd_i.store_payload) begin
        crc_q   <= slcfp_pkg::crc16_byte(crc_q, rx_byte_i);
        count_q <= count_inc[6:0];
      end
      if (cmd_i.load_crc_lo) begin
        crc_lo_q <= rx_byte_i;
      end
      if (cmd_i.start_drain) begin
        rd_idx_q <= '0;
      end else if (cmd_i.drain_step) begin
        rd_idx_q <= rd_next;
      end
    end
  end

  // Payload buffer with a registered read port that runs one entry ahead.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_payload) begin
      mem_q[count_q[Aw-1:0]] <= rx_byte_i;
    end
    if (cmd_i.start_drain) begin
      rd_data_q <= mem_q[0];
    end else if (cmd_i.drain_step && !stat_o.drain_last) begin
      rd_data_q <= mem_q[rd_next[Aw-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (cmd_i.emit_err) begin
        status_q  <= cmd_i.err_status;
        command_q <= '0;
        length_q  <= '0;
        payload_q <= '0;
        index_q   <= '0;
        last_q    <= 1'b1;
      end else if (cmd_i.emit_empty) begin
        status_q  <= slcfp_pkg::StatusGood;
        command_q <= cmd_q;
        length_q  <= '0;
        payload_q <= '0;
        index_q   <= '0;
        last_q    <= 1'b1;
      end else begin
        status_q  <= slcfp_pkg::StatusGood;
        command_q <= cmd_q;
        length_q  <= len_q;
        payload_q <= rd_data_q;
        index_q   <= rd_idx_q[5:0];
        last_q    <= stat_o.drain_last;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign command_o      = command_q;
  assign length_o       = length_q;
  assign payload_byte_o = payload_q;
  assign byte_index_o   = index_q;
  assign last_o         = last_q;

endmodule

FILE: src/sync_length_crc16_frame_parser_top.sv
// Timing: an error or empty-frame result is shown in the cycle after the byte that decides it.
// A good frame of N payload bytes shows its first result once the CRC high byte has started the
// drain and the output register is free. Throughput: one received byte per cycle unless stalled;
// a run of N results holds the input, longer under output stall, set by the single read port.
// Reset: configuration returns to defaults, the parser hunts for sync, output is empty.
// The payload buffer is not cleared: each entry is written in a frame before it is read.
module sync_length_crc16_frame_parser_top #(
  parameter int MaxPayload = slcfp_pkg::MaxPayloadDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Received byte requests.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  // Result requests.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  command_o,
  output logic [6:0]  length_o,
  output logic [7:0]  payload_byte_o,
  output logic [5:0]  byte_index_o,
  output logic        last_o
);

  // The controller walks the frame phases: sync hunt, second sync, length, command,
  // payload, the two CRC bytes and finally the drain of a good frame. It only ever
  // talks to the datapath through the command and status structs below.
  slcfp_pkg::slcfp_cmd_t  cmd;
  slcfp_pkg::slcfp_stat_t stat;

  // Input requests are held off during a drain, and in the length and CRC high phases
  // when the output register holds a stalled result, since those bytes may produce a result.
  // In every other phase a byte is taken even while a result waits to be collected.
  slcfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath keeps the running CRC, frame fields, the payload buffer and the
  // output register. Payload bytes are stored as they arrive and replayed in order
  // once the received CRC matches.
  slcfp_dp #(
    .MaxPayload (MaxPayload)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .rx_byte_i      (rx_byte_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .command_o      (command_o),
    .length_o       (length_o),
    .payload_byte_o (payload_byte_o),
    .byte_index_o   (byte_index_o),
    .last_o         (last_o)
  );

endmodule

FILE: src/slcfp_checker.sv
// Port-level checker for the frame parser, bound to the top level.
// Depends on slcfp_pkg for the status codes.
module slcfp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic [7:0] command_o,
  input logic [6:0] length_o,
  input logic [7:0] payload_byte_o,
  input logic [5:0] byte_index_o,
  input logic       last_o
);

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(payload_byte_o)
      && $stable(byte_index_o) && $stable(status_o))
    else $error("stalled result changed");

  // Error results are single, with command, length and byte index cleared.
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != slcfp_pkg::StatusGood |->
      last_o && command_o == 8'd0 && length_o == 7'd0 && byte_index_o == 6'd0)
    else $error("error result malformed");

  // Only good results can be part of a longer run.
  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == slcfp_pkg::StatusGood && length_o != 7'd0)
    else $error("non-final result is not a good payload byte");

  // The final byte of a non-empty run sits at the end of the payload.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o && status_o == slcfp_pkg::StatusGood && length_o != 7'd0 |->
      byte_index_o == 6'(length_o - 7'd1))
    else $error("final result index does not match length");

endmodule

bind sync_length_crc16_frame_parser_top slcfp_checker u_slcfp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .command_o      (command_o),
  .length_o       (length_o),
  .payload_byte_o (payload_byte_o),
  .byte_index_o   (byte_index_o),
  .last_o         (last_o)
);
